/* src/c345_pkg.sv */
// Package for the 3-4-5 chamfer distance block: function codes, FSM states,
// neighbour offset/weight tables. No dependencies.
`timescale 1ns / 1ps
package c345_pkg;
	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_RUN  = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BORDER,
		ST_FWD,
		ST_BWD,
		ST_DONE
	} state_t;

	localparam int NB_COUNT = 13;
	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z = 2'd2;
	localparam logic [1:0] CFG_MAXD   = 2'd3;

	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
		logic signed [1:0] dz;
		logic [2:0]        w;
	} nb_t;

	// Forward neighbour k; backward is the point mirror with the same weight.
	function automatic nb_t fwd_nb(input logic [3:0] k);
		nb_t n;
		case (k)
			4'd0:  n = '{-2'sd1,  2'sd0,  2'sd0, 3'd3};
			4'd1:  n = '{-2'sd1, -2'sd1,  2'sd0, 3'd4};
			4'd2:  n = '{ 2'sd0, -2'sd1,  2'sd0, 3'd3};
			4'd3:  n = '{ 2'sd1, -2'sd1,  2'sd0, 3'd4};
			4'd4:  n = '{-2'sd1,  2'sd1, -2'sd1, 3'd5};
			4'd5:  n = '{ 2'sd0,  2'sd1, -2'sd1, 3'd4};
			4'd6:  n = '{ 2'sd1,  2'sd1, -2'sd1, 3'd5};
			4'd7:  n = '{-2'sd1,  2'sd0, -2'sd1, 3'd4};
			4'd8:  n = '{ 2'sd0,  2'sd0, -2'sd1, 3'd3};
			4'd9:  n = '{ 2'sd1,  2'sd0, -2'sd1, 3'd4};
			4'd10: n = '{-2'sd1, -2'sd1, -2'sd1, 3'd5};
			4'd11: n = '{ 2'sd0, -2'sd1, -2'sd1, 3'd4};
			4'd12: n = '{ 2'sd1, -2'sd1, -2'sd1, 3'd5};
			default: n = '{2'sd0, 2'sd0, 2'sd0, 3'd0};
		endcase
		return n;
	endfunction
endpackage

/* src/chamfer345_distance_3d.sv */
// Top level: 3D chamfer 3-4-5 distance transform over a voxel RAM.
// Load/read: one item in flight; a run: a border sweep over every voxel, then
// a forward and a backward pass over the interior voxels (one RAM port,
// 14 reads and a write per interior voxel per pass).
// Reset idles control and returns config to its defaults; voxel RAM contents stay undefined.
// Depends on c345_pkg, c345_ram, c345_ctrl.
`timescale 1ns / 1ps
module chamfer345_distance_3d #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64,
	parameter int DIST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [5:0]  coord_x,
	input  logic [5:0]  coord_y,
	input  logic [5:0]  coord_z,
	input  logic        is_pore,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] distance,
	output logic        done_res
);
	import c345_pkg::*;
	localparam int XB = $clog2(MAX_X);
	localparam int YB = $clog2(MAX_Y);
	localparam int ZB = $clog2(MAX_Z);
	localparam int AB = XB + YB + ZB;

	logic [6:0]  size_x_q, size_y_q, size_z_q;
	logic [15:0] maxd_q;

	// Host item in progress: pend_q waits on RAM read data.
	logic        pend_q;
	logic        pend_read_q;
	logic        pend_in_q;
	logic        run_q;
	logic        ov_q;
	logic [15:0] dist_q;
	logic        done_q;

	logic        accept, in_box;
	logic        busy, c_we;
	logic [XB-1:0] c_ax;
	logic [YB-1:0] c_ay;
	logic [ZB-1:0] c_az;
	logic [DIST_BITS-1:0] c_wd, rdata, wd;
	logic        we;
	logic [AB-1:0] addr;
	state_t      cst;

	assign in_box = (32'(coord_x) < MAX_X) && (32'(coord_y) < MAX_Y) &&
		(32'(coord_z) < MAX_Z);
	// Take one item at a time; hold while a result waits unless it leaves now.
	assign in_stall = pend_q || run_q || busy || (ov_q && out_stall);
	assign accept = in_valid && !in_stall;

	c345_ctrl #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .DIST_BITS(DIST_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(accept && func == FUNC_RUN),
		.nx_cfg(size_x_q), .ny_cfg(size_y_q), .nz_cfg(size_z_q), .maxd(maxd_q),
		.rdata(rdata), .busy(busy), .we(c_we),
		.ax(c_ax), .ay(c_ay), .az(c_az), .wdata(c_wd), .state(cst)
	);

	// Route the RAM port: the sequencer owns it during a run.
	always_comb begin
		if (busy) begin
			we = c_we;
			addr = {c_az, c_ay, c_ax};
			wd = c_wd;
		end else begin
			we = accept && func == FUNC_LOAD && in_box;
			addr = {ZB'(coord_z), YB'(coord_y), XB'(coord_x)};
			wd = is_pore ? DIST_BITS'(1) : '0;
		end
	end

	c345_ram #(.WIDTH(DIST_BITS), .DEPTH(2**AB)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 7'd64;
			size_y_q <= 7'd64;
			size_z_q <= 7'd64;
			maxd_q <= 16'hFFFF;
			pend_q <= 1'b0;
			pend_read_q <= 1'b0;
			pend_in_q <= 1'b0;
			run_q <= 1'b0;
			ov_q <= 1'b0;
			dist_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_X: size_x_q <= cfg_data[6:0];
					CFG_SIZE_Y: size_y_q <= cfg_data[6:0];
					CFG_SIZE_Z: size_z_q <= cfg_data[6:0];
					CFG_MAXD:   maxd_q <= cfg_data;
					default: ;
				endcase
			end
			if (ov_q && !out_stall) ov_q <= 1'b0;
			pend_q <= 1'b0;
			if (accept) begin
				case (func)
					FUNC_RUN: run_q <= 1'b1;
					FUNC_READ, FUNC_LOAD: begin
						pend_q <= 1'b1;
						pend_read_q <= (func == FUNC_READ);
						pend_in_q <= in_box;
					end
					default: begin
						ov_q <= 1'b1;
						dist_q <= '0;
						done_q <= 1'b0;
					end
				endcase
			end
			// Present the registered RAM read data through dist_q.
			if (pend_q) begin
				ov_q <= 1'b1;
				done_q <= 1'b1;
				dist_q <= (pend_read_q && pend_in_q) ? 16'(rdata) : '0;
			end
			if (run_q && cst == ST_DONE) begin
				run_q <= 1'b0;
				ov_q <= 1'b1;
				done_q <= 1'b1;
				dist_q <= '0;
			end
		end
	end

	assign out_valid = ov_q;
	assign distance = dist_q;
	assign done_res = done_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept) else $error("item taken during a run");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> (ov_q && $stable(dist_q))) else $error("result lost");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> ov_q) else $error("load/read gave no result");
`endif
endmodule

/* src/c345_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module c345_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* src/c345_ctrl.sv */
// Sequencer for the chamfer block: walks voxels, reads neighbours one per
// cycle, relaxes and writes back. Depends on c345_pkg.
`timescale 1ns / 1ps
module c345_ctrl #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64,
	parameter int DIST_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [6:0]                    nx_cfg,
	input  logic [6:0]                    ny_cfg,
	input  logic [6:0]                    nz_cfg,
	input  logic [15:0]                   maxd,
	input  logic [DIST_BITS-1:0]          rdata,
	output logic                          busy,
	output logic                          we,
	output logic [$clog2(MAX_X)-1:0]      ax,
	output logic [$clog2(MAX_Y)-1:0]      ay,
	output logic [$clog2(MAX_Z)-1:0]      az,
	output logic [DIST_BITS-1:0]          wdata,
	output c345_pkg::state_t              state
);
	import c345_pkg::*;
	localparam int XB = $clog2(MAX_X);
	localparam int YB = $clog2(MAX_Y);
	localparam int ZB = $clog2(MAX_Z);
	localparam int CB = 11;

	state_t st_q, st_d;
	logic [CB-1:0] nx_q, ny_q, nz_q;
	logic [CB-1:0] x_q, y_q, z_q;
	// phase 0: read centre; 1..13: read neighbour k-1; 14: last data; 15: write
	logic [3:0] ph_q;
	logic [DIST_BITS-1:0] cur_q;
	logic [DIST_BITS:0] cand;
	logic [3:0] kprev;
	logic center_pore_q;
	nb_t nb;
	logic signed [CB:0] sx, sy, sz;
	logic last_vox;
	logic [CB-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

	assign state = st_q;
	assign busy = (st_q != ST_IDLE);

	always_comb begin
		lo_x = (st_q == ST_BORDER) ? '0 : CB'(1);
		lo_y = (st_q == ST_BORDER) ? '0 : CB'(1);
		lo_z = (st_q == ST_BORDER) ? '0 : CB'(1);
		hi_x = (st_q == ST_BORDER) ? nx_q - CB'(1) : nx_q - CB'(2);
		hi_y = (st_q == ST_BORDER) ? ny_q - CB'(1) : ny_q - CB'(2);
		hi_z = (st_q == ST_BORDER) ? nz_q - CB'(1) : nz_q - CB'(2);
	end

	always_comb begin
		nb = fwd_nb(ph_q - 4'd1);
		if (st_q == ST_BWD) begin
			nb.dx = -nb.dx;
			nb.dy = -nb.dy;
			nb.dz = -nb.dz;
		end
		sx = $signed({1'b0, x_q});
		sy = $signed({1'b0, y_q});
		sz = $signed({1'b0, z_q});
		// the border sweep only ever touches the voxel itself
		if ((st_q == ST_FWD || st_q == ST_BWD) && ph_q >= 4'd1 && ph_q <= 4'd13) begin
			sx = sx + (CB+1)'(nb.dx);
			sy = sy + (CB+1)'(nb.dy);
			sz = sz + (CB+1)'(nb.dz);
		end
		ax = XB'(sx);
		ay = YB'(sy);
		az = ZB'(sz);
	end

	// Data arriving this cycle belongs to the read issued at ph_q-1.
	assign kprev = ph_q - 4'd2;
	always_comb begin
		nb_t pn;
		pn = fwd_nb(kprev);
		cand = {1'b0, rdata} + (DIST_BITS+1)'(pn.w);
	end

	always_comb begin
		if (st_q == ST_BWD) begin
			last_vox = (x_q == lo_x) && (y_q == lo_y) && (z_q == lo_z);
		end else begin
			last_vox = (x_q == hi_x) && (y_q == hi_y) && (z_q == hi_z);
		end
	end

	always_comb begin
		st_d = st_q;
		we = 1'b0;
		wdata = cur_q;
		case (st_q)
			ST_IDLE: begin
				if (start) begin
					st_d = (nx_cfg == '0 || ny_cfg == '0 || nz_cfg == '0) ? ST_DONE :
						ST_BORDER;
				end
			end
			ST_BORDER: begin
				// phase 1: data of the voxel is present
				if (ph_q == 4'd1) begin
					we = (rdata != '0) && ((x_q == '0) || (x_q == hi_x) ||
						(y_q == '0) || (y_q == hi_y) || (z_q == '0) || (z_q == hi_z));
					wdata = DIST_BITS'(3);
					if (last_vox) begin
						// no interior when any extent is below 3
						st_d = (nx_q < CB'(3) || ny_q < CB'(3) || nz_q < CB'(3)) ?
							ST_DONE : ST_FWD;
					end
				end
			end
			ST_FWD, ST_BWD: begin
				if (ph_q == 4'd15) begin
					we = center_pore_q;
					if (last_vox) st_d = (st_q == ST_FWD) ? ST_BWD : ST_DONE;
				end
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
			cur_q <= '0;
			center_pore_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					nx_q <= (CB'(nx_cfg) > CB'(MAX_X)) ? CB'(MAX_X) : CB'(nx_cfg);
					ny_q <= (CB'(ny_cfg) > CB'(MAX_Y)) ? CB'(MAX_Y) : CB'(ny_cfg);
					nz_q <= (CB'(nz_cfg) > CB'(MAX_Z)) ? CB'(MAX_Z) : CB'(nz_cfg);
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
					ph_q <= '0;
				end
				ST_BORDER: begin
					ph_q <= (ph_q == 4'd1) ? '0 : ph_q + 4'd1;
					if (ph_q == 4'd1) begin
						if (last_vox) begin
							x_q <= CB'(1);
							y_q <= CB'(1);
							z_q <= CB'(1);
						end else if (x_q != hi_x) begin
							x_q <= x_q + CB'(1);
						end else begin
							x_q <= '0;
							if (y_q != hi_y) y_q <= y_q + CB'(1);
							else begin
								y_q <= '0;
								z_q <= z_q + CB'(1);
							end
						end
					end
				end
				ST_FWD, ST_BWD: begin
					// phase 15 wraps back to 0
					ph_q <= ph_q + 4'd1;
					if (ph_q == 4'd1) begin
						center_pore_q <= (rdata != '0);
						cur_q <= (st_q == ST_FWD) ? DIST_BITS'(maxd) : rdata;
					end else if (ph_q >= 4'd2 && ph_q <= 4'd14) begin
						if (cand < {1'b0, cur_q}) cur_q <= cand[DIST_BITS-1:0];
					end
					if (ph_q == 4'd15) begin
						if (last_vox) begin
							x_q <= nx_q - CB'(2);
							y_q <= ny_q - CB'(2);
							z_q <= nz_q - CB'(2);
						end else if (st_q == ST_FWD) begin
							if (x_q != hi_x) x_q <= x_q + CB'(1);
							else begin
								x_q <= CB'(1);
								if (y_q != hi_y) y_q <= y_q + CB'(1);
								else begin
									y_q <= CB'(1);
									z_q <= z_q + CB'(1);
								end
							end
						end else begin
							if (x_q != lo_x) x_q <= x_q - CB'(1);
							else begin
								x_q <= hi_x;
								if (y_q != lo_y) y_q <= y_q - CB'(1);
								else begin
									y_q <= hi_y;
									z_q <= z_q - CB'(1);
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* sim/tb_top.sv */
// Testbench for chamfer345_distance_3d: loads voxel boxes, runs the 3-4-5 transform,
// reads distances back and checks every result against a built-in predictor.
// Depends on c345_pkg and the chamfer345_distance_3d RTL.
`timescale 1ns / 1ps
module tb_top;
	import c345_pkg::*;

	localparam int SIDE = 64;
	localparam int VOXELS = SIDE * SIDE * SIDE;

	// Tracks expected results: a private copy of the voxel volume, the box
	// settings and a queue of results still owed by the block.
	class dist_scoreboard;
		typedef struct packed {
			logic [15:0] dval;
			logic        done;
		} res_t;

		logic [15:0] vol [VOXELS];
		int unsigned box_x, box_y, box_z, top_dist;
		res_t want_q [$];
		int errors, matched, runs, reads;
		// forward (causal) neighbours; backward ones are their point mirror
		int ofs_x [13] = '{-1, -1, 0, 1, -1, 0, 1, -1, 0, 1, -1, 0, 1};
		int ofs_y [13] = '{0, -1, -1, -1, 1, 1, 1, 0, 0, 0, -1, -1, -1};
		int ofs_z [13] = '{0, 0, 0, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1};
		int wgt [13] = '{3, 4, 3, 4, 5, 4, 5, 4, 3, 4, 5, 4, 5};

		function new();
			box_x = 64;
			box_y = 64;
			box_z = 64;
			top_dist = 65535;
		endfunction

		function int vix(int x, int y, int z);
			return (z * SIDE + y) * SIDE + x;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_SIZE_X: box_x = 32'(val[6:0]);
				CFG_SIZE_Y: box_y = 32'(val[6:0]);
				CFG_SIZE_Z: box_z = 32'(val[6:0]);
				CFG_MAXD:   top_dist = 32'(val);
				default: ;
			endcase
		endfunction

		function int relax(int cur, int x, int y, int z, int dir);
			int k, c;
			for (k = 0; k < 13; k++) begin
				c = vol[vix(x + dir * ofs_x[k], y + dir * ofs_y[k], z + dir * ofs_z[k])] + wgt[k];
				if (c < cur)
					cur = c;
			end
			return cur;
		endfunction

		function void transform();
			int nx, ny, nz, x, y, z, i;
			nx = (box_x > SIDE) ? SIDE : box_x;
			ny = (box_y > SIDE) ? SIDE : box_y;
			nz = (box_z > SIDE) ? SIDE : box_z;
			// border pores hold 3 whatever the distance limit
			for (z = 0; z < nz; z++)
				for (y = 0; y < ny; y++)
					for (x = 0; x < nx; x++) begin
						i = vix(x, y, z);
						if ((x == 0 || x == nx - 1 || y == 0 || y == ny - 1 ||
						     z == 0 || z == nz - 1) && vol[i] != 0)
							vol[i] = 16'd3;
					end
			for (z = 1; z < nz - 1; z++)
				for (y = 1; y < ny - 1; y++)
					for (x = 1; x < nx - 1; x++) begin
						i = vix(x, y, z);
						if (vol[i] != 0)
							vol[i] = 16'(relax(top_dist, x, y, z, 1));
					end
			// an interior pore that ended at 0 counts as solid here
			for (z = nz - 2; z > 0; z--)
				for (y = ny - 2; y > 0; y--)
					for (x = nx - 2; x > 0; x--) begin
						i = vix(x, y, z);
						if (vol[i] != 0)
							vol[i] = 16'(relax(vol[i], x, y, z, -1));
					end
		endfunction

		// Note an accepted item and queue the result it owes.
		function void note_item(func_t f, logic [5:0] x, logic [5:0] y, logic [5:0] z,
		                        logic pore);
			res_t r;
			r = '0;
			case (f)
				FUNC_LOAD: begin
					vol[vix(int'(x), int'(y), int'(z))] = pore ? 16'd1 : 16'd0;
					r.done = 1'b1;
				end
				FUNC_RUN: begin
					transform();
					runs++;
					r.done = 1'b1;
				end
				FUNC_READ: begin
					r.dval = vol[vix(int'(x), int'(y), int'(z))];
					reads++;
					r.done = 1'b1;
				end
				default: r = '0;
			endcase
			want_q.push_back(r);
		endfunction

		task report(string what);
			$display("%0t ns  MISMATCH: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [15:0] got_dist, logic done);
			res_t w;
			if (want_q.size() == 0) begin
				report($sformatf("unexpected result distance=%0d done=%0b", got_dist, done));
			end else begin
				w = want_q.pop_front();
				if (got_dist !== w.dval)
					report($sformatf("distance %0d, want %0d", got_dist, w.dval));
				else if (done !== w.done)
					report($sformatf("done_res %0b, want %0b", done, w.done));
				else
					matched++;
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [5:0]  coord_x;
	logic [5:0]  coord_y;
	logic [5:0]  coord_z;
	logic        is_pore;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] distance;
	logic        done_res;

	dist_scoreboard sb;
	int burst_left;
	int stall_mode;
	int stall_hold;
	int mode_left;
	logic [17:0] loaded_q [$];	// {z, y, x} of every voxel ever loaded

	chamfer345_distance_3d DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.is_pore(is_pore),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.done_res(done_res)
	);

	always #6 clk = ~clk;

	// Receiver: switch between no stall, sparse random stall and long stall runs.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(20, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_hold == 0) begin
					out_stall <= ~out_stall;
					stall_hold <= $urandom_range(1, 20);
				end else begin
					stall_hold <= stall_hold - 1;
				end
			end
		endcase
	end

	// Monitor: check every result the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(distance, done_res);
	end

	// Present one item, hold it until accepted, then maybe drop valid for a gap.
	task send_item(func_t f, logic [5:0] x, logic [5:0] y, logic [5:0] z, logic pore);
		func <= f;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		is_pore <= pore;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(f, x, y, z, pore);
		if (f == FUNC_LOAD)
			loaded_q.push_back({z, y, x});
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long stretch with no gaps
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
			             $urandom_range(1, 8);
		end
	endtask

	// Wait until every owed result has arrived.
	task wait_drained();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.want_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task read_loaded();
		logic [17:0] c;
		c = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
		send_item(FUNC_READ, c[5:0], c[11:6], c[17:12], 1'b0);
	endtask

	// One box setting: program it, fill the box, run, then a random mix.
	task run_phase(int sx, int sy, int sz, int md, int n_rand);
		int x, y, z, k, pick;
		wait_drained();
		write_reg(CFG_SIZE_X, 16'(sx));
		write_reg(CFG_SIZE_Y, 16'(sy));
		write_reg(CFG_SIZE_Z, 16'(sz));
		write_reg(CFG_MAXD, 16'(md));
		// mostly pore so that the transform has real work
		for (z = 0; z < sz; z++)
			for (y = 0; y < sy; y++)
				for (x = 0; x < sx; x++)
					send_item(FUNC_LOAD, 6'(x), 6'(y), 6'(z), $urandom_range(0, 9) < 7);
		send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
		for (k = 0; k < n_rand; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				read_loaded();
			else if (pick < 65)
				send_item(FUNC_LOAD, 6'($urandom_range(0, sx - 1)),
				          6'($urandom_range(0, sy - 1)), 6'($urandom_range(0, sz - 1)),
				          $urandom_range(0, 9) < 7);
			else if (pick < 85)
				send_item(FUNC_LOAD, 6'($urandom), 6'($urandom), 6'($urandom),
				          1'($urandom));
			else if (pick < 91)
				send_item(FUNC_NONE, 6'($urandom), 6'($urandom), 6'($urandom),
				          1'($urandom));
			else
				send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 6'($urandom),
				          1'($urandom));
		end
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SIZE_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		func <= FUNC_NONE;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		is_pore <= 1'b0;
		out_stall <= 1'b0;
		stall_mode <= 0;
		stall_hold <= 0;
		mode_left <= 0;
		burst_left = 4;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner coordinates, both voxel kinds, unknown function.
		send_item(FUNC_LOAD, 6'd0, 6'd0, 6'd0, 1'b1);
		send_item(FUNC_LOAD, 6'd63, 6'd63, 6'd63, 1'b1);
		send_item(FUNC_LOAD, 6'd63, 6'd0, 6'd63, 1'b0);
		send_item(FUNC_LOAD, 6'd0, 6'd63, 6'd0, 1'b0);
		send_item(FUNC_LOAD, 6'd42, 6'd21, 6'd42, 1'b1);
		send_item(FUNC_READ, 6'd0, 6'd0, 6'd0, 1'b0);
		send_item(FUNC_READ, 6'd63, 6'd63, 6'd63, 1'b1);
		send_item(FUNC_READ, 6'd63, 6'd0, 6'd63, 1'b0);
		send_item(FUNC_READ, 6'd0, 6'd63, 6'd0, 1'b1);
		send_item(FUNC_READ, 6'd42, 6'd21, 6'd42, 1'b0);
		send_item(FUNC_NONE, 6'd63, 6'd63, 6'd63, 1'b1);
		send_item(FUNC_NONE, 6'd0, 6'd0, 6'd0, 1'b0);

		// Box settings: smallest box, each axis stretched in turn, the distance
		// limit at 0, below the border value and at its top, then random mixes.
		run_phase(3, 3, 3, 65535, 30);
		run_phase(10, 3, 3, 0, 25);
		run_phase(3, 8, 3, 2, 25);
		run_phase(3, 3, 8, 65535, 25);
		run_phase(4, 4, 5, 7, 30);
		run_phase(4, 3, 5, $urandom_range(0, 65535), 25);
		run_phase($urandom_range(3, 4), $urandom_range(3, 4), $urandom_range(3, 4),
		          $urandom_range(3, 20), 20);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d transform runs and %0d distance reads over 7 box settings;",
		         sb.runs, sb.reads);
		$display("%0d results matched, %0d mismatches.", sb.matched, sb.errors);
		if (sb.errors == 0 && sb.want_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#12_000_000;
		$display("tb_top failed");
		$finish;
	end
endmodule

/* sim.f */
src/c345_pkg.sv
src/c345_ram.sv
src/c345_ctrl.sv
src/chamfer345_distance_3d.sv
sim/tb_top.sv
